[hw/rtl/wsc_pkg.sv]
// ----------------------------------------------------------------------------
// wsc_pkg
// Types and constants shared by the wheel speed capture filter.
// ----------------------------------------------------------------------------
package wsc_pkg;

  localparam int NUM_WHEELS   = 4;
  localparam int WHEEL_BITS   = 2;
  localparam int COUNTER_BITS = 32;
  localparam int NUM_BITS     = 52;   // tick_frequency * circumference
  localparam int DEN_BITS     = 40;   // period * teeth
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [16:0] ALPHA_ONE = 17'h10000;

  typedef enum logic {
    KIND_CAPTURE = 1'b0,
    KIND_UPDATE  = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    REG_TICK_FREQUENCY = 3'd0,
    REG_TIMER_TOP      = 3'd1,
    REG_FRONT_TEETH    = 3'd2,
    REG_REAR_TEETH     = 3'd3,
    REG_FRONT_CIRC     = 3'd4,
    REG_REAR_CIRC      = 3'd5,
    REG_ALPHA          = 3'd6,
    REG_STALE_LIMIT    = 3'd7
  } reg_index_t;

  typedef struct packed {
    kind_t                    kind;
    logic [WHEEL_BITS-1:0]    wheel_id;
    logic [31:0]              now_ms;
    logic [COUNTER_BITS-1:0]  capture_count;
  } item_t;

  typedef struct packed {
    logic [27:0]             tick_frequency;
    logic [COUNTER_BITS-1:0] timer_top;
    logic [7:0]              front_teeth;
    logic [7:0]              rear_teeth;
    logic [23:0]             front_circumference;
    logic [23:0]             rear_circumference;
    logic [16:0]             smoothing_alpha;
    logic [15:0]             stale_limit;
  } cfg_t;

endpackage

[hw/rtl/wsc_front.sv]
// ----------------------------------------------------------------------------
// wsc_front
// Accepts input words, tags them capture or update, and queues them.
// ----------------------------------------------------------------------------
module wsc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_command,
  input  logic [1:0]    in_wheel,
  input  logic [31:0]   in_now,
  input  logic [31:0]   in_capture,
  output logic          item_valid,
  output wsc_pkg::item_t item,
  input  logic          item_pop
);

  wsc_pkg::item_t entry [wsc_pkg::QUEUE_DEPTH];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;
  wsc_pkg::item_t word_in;

  always_comb begin
    word_in.kind          = in_command ? wsc_pkg::KIND_UPDATE : wsc_pkg::KIND_CAPTURE;
    word_in.wheel_id      = in_wheel;
    word_in.now_ms        = in_now;
    word_in.capture_count = in_capture[wsc_pkg::COUNTER_BITS-1:0];
  end

  assign in_ready   = (count != 2'(wsc_pkg::QUEUE_DEPTH));
  assign push       = in_valid && in_ready;
  assign item_valid = (count != 2'd0);
  assign pop        = item_pop && item_valid;
  assign item       = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= word_in;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

[hw/rtl/wsc_div.sv]
// ----------------------------------------------------------------------------
// wsc_div
// Restoring divider, one quotient bit per cycle, saturated to 32 bits.
// ----------------------------------------------------------------------------
module wsc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [wsc_pkg::NUM_BITS-1:0]  num,
  input  logic [wsc_pkg::DEN_BITS-1:0]  den,
  output logic                          done,
  output logic [31:0]                   quotient
);

  localparam int STEP_BITS = $clog2(wsc_pkg::NUM_BITS + 1);

  logic [wsc_pkg::NUM_BITS-1:0] dividend;
  logic [wsc_pkg::NUM_BITS-1:0] quo;
  logic [wsc_pkg::DEN_BITS:0]   rem;
  logic [wsc_pkg::DEN_BITS-1:0] divisor;
  logic [STEP_BITS-1:0]         steps;
  logic                         busy;
  logic [wsc_pkg::DEN_BITS:0]   shifted;
  logic                         fits;

  assign shifted  = {rem[wsc_pkg::DEN_BITS-1:0], dividend[wsc_pkg::NUM_BITS-1]};
  assign fits     = (shifted >= {1'b0, divisor});
  assign quotient = (|quo[wsc_pkg::NUM_BITS-1:32]) ? 32'hFFFF_FFFF : quo[31:0];

  always_ff @(posedge clk) begin
    if (start) begin
      dividend <= num;
      divisor  <= den;
      rem      <= '0;
      quo      <= '0;
    end else if (busy) begin
      dividend <= {dividend[wsc_pkg::NUM_BITS-2:0], 1'b0};
      rem      <= fits ? shifted - {1'b0, divisor} : shifted;
      quo      <= {quo[wsc_pkg::NUM_BITS-2:0], fits};
    end
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_BITS'(wsc_pkg::NUM_BITS);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[hw/rtl/wsc_back.sv]
// ----------------------------------------------------------------------------
// wsc_back
// Per-wheel state, capture bookkeeping and the speed filter sequencer.
// ----------------------------------------------------------------------------
module wsc_back (
  input  logic           clk,
  input  logic           rst,
  input  wsc_pkg::cfg_t  cfg,
  input  logic           item_valid,
  input  wsc_pkg::item_t item,
  output logic           item_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_wheel,
  output logic [31:0]    out_speed,
  output logic           out_last
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_MUL, S_DIV, S_MIX, S_SUM, S_OUT
  } state_t;

  localparam int WB = wsc_pkg::WHEEL_BITS;
  localparam int CB = wsc_pkg::COUNTER_BITS;

  state_t      state;
  logic [CB-1:0] previous_capture [wsc_pkg::NUM_WHEELS];
  logic [CB-1:0] tooth_period     [wsc_pkg::NUM_WHEELS];
  logic [31:0] last_seen_ms     [wsc_pkg::NUM_WHEELS];
  logic [31:0] smoothed_speed   [wsc_pkg::NUM_WHEELS];
  logic [wsc_pkg::NUM_WHEELS-1:0] capture_seen;
  logic [wsc_pkg::NUM_WHEELS-1:0] filter_ready;

  logic [WB-1:0] wheel;
  logic [31:0]   now;
  logic [wsc_pkg::NUM_BITS-1:0] num;
  logic [wsc_pkg::DEN_BITS-1:0] den;
  logic          div_start;
  logic          div_done;
  logic [31:0]   raw;
  logic [48:0]   prod_new;
  logic [48:0]   prod_old;

  logic          front;
  logic [7:0]    teeth;
  logic [23:0]   circ;
  logic [16:0]   alpha;
  logic [31:0]   elapsed;
  logic [CB-1:0] cap_prev;
  logic [CB-1:0] new_period;
  logic [49:0]   mix;

  assign front    = (wheel < WB'(2));
  assign teeth    = front ? cfg.front_teeth : cfg.rear_teeth;
  assign circ     = front ? cfg.front_circumference : cfg.rear_circumference;
  assign alpha    = (cfg.smoothing_alpha > wsc_pkg::ALPHA_ONE) ?
                    wsc_pkg::ALPHA_ONE : cfg.smoothing_alpha;
  assign elapsed  = now - last_seen_ms[wheel];
  assign cap_prev = previous_capture[item.wheel_id];
  // count wraps after timer_top
  assign new_period = (item.capture_count >= cap_prev) ?
                      item.capture_count - cap_prev :
                      cfg.timer_top - cap_prev + item.capture_count + CB'(1);
  assign mix      = 50'(prod_new) + 50'(prod_old) + 50'd32768;
  assign item_pop = (state == S_IDLE);
  assign div_start = (state == S_MUL);

  wsc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (num),
    .den      (den),
    .done     (div_done),
    .quotient (raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wheel     <= '0;
      out_valid <= 1'b0;
      out_last  <= 1'b0;
      capture_seen <= '0;
      filter_ready <= '0;
      for (int i = 0; i < wsc_pkg::NUM_WHEELS; i++) begin
        previous_capture[i] <= '0;
        tooth_period[i]     <= '0;
        last_seen_ms[i]     <= '0;
        smoothed_speed[i]   <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            if (item.kind == wsc_pkg::KIND_CAPTURE) begin
              if (capture_seen[item.wheel_id]) begin
                tooth_period[item.wheel_id] <= new_period;
              end
              previous_capture[item.wheel_id] <= item.capture_count;
              last_seen_ms[item.wheel_id]     <= item.now_ms;
              capture_seen[item.wheel_id]     <= 1'b1;
            end else begin
              now   <= item.now_ms;
              wheel <= '0;
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (elapsed > 32'(cfg.stale_limit)) begin
            smoothed_speed[wheel] <= '0;
            filter_ready[wheel]   <= 1'b0;
            out_speed <= '0;
            state     <= S_OUT;
          end else if (tooth_period[wheel] == '0) begin
            out_speed <= smoothed_speed[wheel];
            state     <= S_OUT;
          end else begin
            num   <= 52'(cfg.tick_frequency) * 52'(circ);
            den   <= 40'(tooth_period[wheel]) *
                     40'((teeth == 8'd0) ? 8'd1 : teeth);
            state <= S_MUL;
          end
          out_wheel <= wheel;
          out_last  <= (wheel == WB'(wsc_pkg::NUM_WHEELS - 1));
        end
        S_MUL: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            if (!filter_ready[wheel]) begin
              filter_ready[wheel]   <= 1'b1;
              smoothed_speed[wheel] <= raw;
              out_speed <= raw;
              state     <= S_OUT;
            end else begin
              prod_new <= 49'(alpha) * 49'(raw);
              prod_old <= 49'(wsc_pkg::ALPHA_ONE - alpha) * 49'(smoothed_speed[wheel]);
              state    <= S_MIX;
            end
          end
        end
        S_MIX: state <= S_SUM;
        S_SUM: begin
          smoothed_speed[wheel] <= (|mix[49:48]) ? 32'hFFFF_FFFF : mix[47:16];
          out_speed <= (|mix[49:48]) ? 32'hFFFF_FFFF : mix[47:16];
          state     <= S_OUT;
        end
        S_OUT: begin
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              state <= S_IDLE;
            end else begin
              wheel <= wheel + 1'b1;
              state <= S_CHECK;
            end
          end else begin
            out_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/wheel_speed_capture_filter.sv]
// ----------------------------------------------------------------------------
// wheel_speed_capture_filter
// Four-wheel speed estimator from tooth capture counts, with EMA smoothing.
// ----------------------------------------------------------------------------
// Use:
//   s_axis: one word per event. tuser = command (0 capture, 1 update).
//     A capture stores the wheel's count and time and, from its second
//     capture on, the tooth period (wrapping at timer_top). No output.
//   m_axis: an update yields four words, wheel 0 to 3, tlast on wheel 3;
//     tuser = wheel index, tdata = filtered speed, unsigned Q16.16 m/s.
//   cfg: register writes (index, data), taken every cycle; write only idle.
// Flow:
//   The back end takes a capture while idle. Per wheel, an update steps
//   through check, multiply, the 52-step serial divider, mix and sum
//   (mix and sum only once the filter holds a speed) when a new speed is
//   computed, or check alone when the speed is timed out or held; each wheel then waits in output for the handshake.
//   A 2-word queue in front accepts input while the back end works.
// Reset clears all wheel state and loads the default registers.
// A stalled m_axis holds its word; the back end waits and the queue fills.
// ----------------------------------------------------------------------------
module wheel_speed_capture_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // [1:0] wheel_id, [33:2] now_ms, [65:34] capture_count
  input  logic        s_tuser,   // [0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] speed
  output logic [1:0]  m_tuser,   // [1:0] speed_wheel
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  wsc_pkg::cfg_t  cfg;
  wsc_pkg::item_t item;
  logic           item_valid;
  logic           item_pop;

  assign cfg_ready = 1'b1;

  // register file; every index in range is a register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_frequency      <= 28'd1000000;
      cfg.timer_top           <= 32'd65535;
      cfg.front_teeth         <= 8'd1;
      cfg.rear_teeth          <= 8'd1;
      cfg.front_circumference <= 24'd104858;
      cfg.rear_circumference  <= 24'd104858;
      cfg.smoothing_alpha     <= 17'd13107;
      cfg.stale_limit         <= 16'd100;
    end else if (cfg_valid) begin
      unique case (wsc_pkg::reg_index_t'(cfg_index))
        wsc_pkg::REG_TICK_FREQUENCY: cfg.tick_frequency      <= cfg_data[27:0];
        wsc_pkg::REG_TIMER_TOP:      cfg.timer_top           <= cfg_data;
        wsc_pkg::REG_FRONT_TEETH:    cfg.front_teeth         <= cfg_data[7:0];
        wsc_pkg::REG_REAR_TEETH:     cfg.rear_teeth          <= cfg_data[7:0];
        wsc_pkg::REG_FRONT_CIRC:     cfg.front_circumference <= cfg_data[23:0];
        wsc_pkg::REG_REAR_CIRC:      cfg.rear_circumference  <= cfg_data[23:0];
        wsc_pkg::REG_ALPHA:          cfg.smoothing_alpha     <= cfg_data[16:0];
        wsc_pkg::REG_STALE_LIMIT:    cfg.stale_limit         <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  wsc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_command (s_tuser),
    .in_wheel   (s_tdata[1:0]),
    .in_now     (s_tdata[33:2]),
    .in_capture (s_tdata[65:34]),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  wsc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_wheel  (m_tuser),
    .out_speed  (m_tdata),
    .out_last   (m_tlast)
  );

`ifndef SYNTHESIS
  // tlast only on the final wheel
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser == 2'd3)
    else $error("tlast on wrong wheel");

  // a handshake on a non-final wheel clears the output valid
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> !m_tvalid)
    else $error("output word not cleared after handshake");

  // output is idle right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");
`endif

endmodule
